/* rtl/etfp_pkg.sv */
// shared types and constants for the escape-time fractal pixel evaluator
// transaction payload structs, register indexes, fixed-point constants, palette
// no dependencies
`default_nettype none

package etfp_pkg;

   localparam int FRAC_BITS   = 24;
   localparam int C_W         = 27;
   localparam int Z_W         = 32;
   localparam int MAG_W       = 13;
   localparam int COUNT_W     = 5;
   localparam int COLOR_W     = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int COUNT_MAX   = 31;
   localparam int RECIP_SHIFT = 18;
   localparam int FIVE_SHIFT  = 20;

   // multiply by this and shift right by RECIP_SHIFT gives floor(mag / 5)
   localparam logic signed [Z_W-1:0] RECIP_FIVE = 32'sd52429;

   // 4.0 in the format of a sum of two squares
   localparam logic signed [2*Z_W:0] ESCAPE_LIMIT = 65'sh4_0000_0000_0000;

   localparam logic signed [C_W-1:0] JULIA_C_REAL_RESET = -27'sd14008975;
   localparam logic signed [C_W-1:0] JULIA_C_IMAG_RESET = -27'sd3893992;

   localparam logic [CSR_IDX_W-1:0] CSR_FRACTAL_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JULIA_C_REAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_JULIA_C_IMAG = 2'd2;

   typedef struct packed {
      logic [8:0] pixel_x;
      logic [7:0] pixel_y;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] escape_count;
      logic [COLOR_W-1:0] pixel_color;
   } rsp_payload_type;

   // round(rem * 2^24 / 80) for rem = mag mod 5, scaled by 2^20 / 5
   function automatic logic [FIVE_SHIFT-1:0] fifth_frac(input logic [2:0] rem);
      logic [FIVE_SHIFT-1:0] frac;
      begin
         case (rem)
            3'd1:    frac = 20'd209715;
            3'd2:    frac = 20'd419430;
            3'd3:    frac = 20'd629146;
            3'd4:    frac = 20'd838861;
            default: frac = 20'd0;
         endcase
         return frac;
      end
   endfunction

   function automatic logic [COLOR_W-1:0] blue_palette(input logic [COUNT_W-1:0] count);
      logic [3:0]         idx;
      logic [COLOR_W-1:0] color;
      begin
         idx = (count > 5'd15) ? 4'd15 : count[3:0];
         case (idx)
            4'd0:    color = 8'd0;
            4'd1:    color = 8'd24;
            4'd2:    color = 8'd25;
            4'd3:    color = 8'd26;
            4'd4:    color = 8'd27;
            4'd5:    color = 8'd28;
            4'd6:    color = 8'd29;
            4'd7:    color = 8'd30;
            4'd8:    color = 8'd31;
            4'd9:    color = 8'd63;
            4'd10:   color = 8'd95;
            4'd11:   color = 8'd127;
            4'd12:   color = 8'd159;
            4'd13:   color = 8'd191;
            4'd14:   color = 8'd223;
            default: color = 8'd255;
         endcase
         return color;
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/escape_time_fractal_pixel.sv */
// escape-time fractal pixel evaluator, Mandelbrot or Julia, one pixel per transaction
// one shared 32x32 signed multiplier under a small sequencer
// depends on etfp_pkg
//
// usage:
//   req channel carries pixel_x / pixel_y; req_stall is high while a pixel is in work
//   rsp channel returns escape_count and the blue palette color for that pixel
//   csr port writes fractal_mode, julia_c_real, julia_c_imag; the user must write them
//   only while the block is idle, which the block itself does not enforce
// sequence:
//   coordinate mapping (MAPX, MAPY, MAPD) comes first, then each iteration runs
//   a*a, b*b, a*b and the update on the shared multiplier; a pixel ends at its
//   escape step or after MAX_ITERATIONS iterations; the next pixel is taken once
//   its predecessor's result is registered
// reset:
//   synchronous; the sequencer goes idle, rsp_valid drops, csr registers take defaults
// stall:
//   a result waits in the output register under rsp_stall while the next pixel
//   is accepted and computed; a finished pixel holds until the register frees up
`default_nettype none

module escape_time_fractal_pixel #(
   parameter int SCREEN_WIDTH   = 320,
   parameter int SCREEN_HEIGHT  = 240,
   parameter int MAX_ITERATIONS = 16
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  etfp_pkg::req_payload_type              req_payload,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output etfp_pkg::rsp_payload_type              rsp_payload,
   input  wire                                    csr_wen,
   input  wire  [etfp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire  [etfp_pkg::C_W-1:0]               csr_wdata
);

   import etfp_pkg::*;

   localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);
   localparam int DELTA_W = MAG_W + 1;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_MAPX = 9'b000000010,
      S_MAPY = 9'b000000100,
      S_MAPD = 9'b000001000,
      S_SQA  = 9'b000010000,
      S_SQB  = 9'b000100000,
      S_TEST = 9'b001000000,
      S_UPD  = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   state_type                   state_ff, state_in;

   logic                        mode_ff;
   logic signed [C_W-1:0]       c_real_ff, c_imag_ff;

   logic [MAG_W-1:0]            magx_ff, magx_in, magy_ff, magy_in;
   logic                        negx_ff, negx_in, negy_ff, negy_in;
   logic signed [Z_W-1:0]       a_ff, a_in, b_ff, b_in;
   logic signed [Z_W-1:0]       cr_ff, cr_in, ci_ff, ci_in;
   logic signed [2*Z_W-1:0]     mul_ff, mul_in;
   logic signed [2*Z_W-1:0]     u_ff, u_in, diff_ff, diff_in;
   logic [ITER_W-1:0]           iter_ff, iter_in;
   logic [COUNT_W-1:0]          count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_payload_type             rsp_payload_ff, rsp_payload_in;

   logic signed [Z_W-1:0]       op_a, op_b;
   logic signed [DELTA_W-1:0]   delta_x, delta_y;
   logic signed [Z_W-1:0]       map_val;
   logic signed [2*Z_W:0]       radius_sq;
   logic [ITER_W-1:0]           iter_next;
   logic                        req_take, rsp_take;

   // mag / 5 from the reciprocal product, then scale to mag / 80 in Q.24 with rounding
   function automatic logic signed [Z_W-1:0] map_coord(
      input logic [MAG_W-1:0]      mag,
      input logic signed [2*Z_W-1:0] prod,
      input logic                  neg
   );
      logic [MAG_W:0]   quo;
      logic [MAG_W+2:0] five_q;
      logic [MAG_W+2:0] rem;
      logic [Z_W-1:0]   q;
      begin
         quo    = prod[RECIP_SHIFT+MAG_W:RECIP_SHIFT];
         five_q = ((MAG_W+3)'(quo) << 2) + (MAG_W+3)'(quo);
         rem    = (MAG_W+3)'(mag) - five_q;
         q      = (Z_W'(quo) << FIVE_SHIFT) + Z_W'(fifth_frac(rem[2:0]));
         return neg ? -signed'(q) : signed'(q);
      end
   endfunction

   assign req_stall   = (state_ff != S_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign rsp_take    = rsp_valid_ff && !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign delta_x = signed'(DELTA_W'(req_payload.pixel_x)) - DELTA_W'(SCREEN_WIDTH / 2);
   assign delta_y = signed'(DELTA_W'(req_payload.pixel_y)) - DELTA_W'(SCREEN_HEIGHT / 2);

   assign map_val   = (state_ff == S_MAPY) ? map_coord(magx_ff, mul_ff, negx_ff)
                                           : map_coord(magy_ff, mul_ff, negy_ff);
   assign radius_sq = (2*Z_W+1)'(u_ff) + (2*Z_W+1)'(mul_ff);
   assign iter_next = iter_ff + ITER_W'(1);

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         S_MAPX: begin
            op_a = signed'(Z_W'(magx_ff));
            op_b = RECIP_FIVE;
         end
         S_MAPY: begin
            op_a = signed'(Z_W'(magy_ff));
            op_b = RECIP_FIVE;
         end
         S_SQA: begin
            op_a = a_ff;
            op_b = a_ff;
         end
         S_SQB: begin
            op_a = b_ff;
            op_b = b_ff;
         end
         S_TEST: begin
            op_a = a_ff;
            op_b = b_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign mul_in = op_a * op_b;

   always_comb begin
      state_in       = state_ff;
      magx_in        = magx_ff;
      magy_in        = magy_ff;
      negx_in        = negx_ff;
      negy_in        = negy_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      cr_in          = cr_ff;
      ci_in          = ci_ff;
      u_in           = u_ff;
      diff_in        = diff_ff;
      iter_in        = iter_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_take;
      rsp_payload_in = rsp_payload_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               negx_in  = delta_x[DELTA_W-1];
               negy_in  = delta_y[DELTA_W-1];
               magx_in  = MAG_W'(delta_x[DELTA_W-1] ? -delta_x : delta_x);
               magy_in  = MAG_W'(delta_y[DELTA_W-1] ? -delta_y : delta_y);
               state_in = S_MAPX;
            end
         end
         S_MAPX: begin
            state_in = S_MAPY;
         end
         S_MAPY: begin
            a_in     = map_val;
            state_in = S_MAPD;
         end
         S_MAPD: begin
            b_in     = map_val;
            cr_in    = mode_ff ? Z_W'(c_real_ff) : a_ff;
            ci_in    = mode_ff ? Z_W'(c_imag_ff) : map_val;
            iter_in  = '0;
            state_in = S_SQA;
         end
         S_SQA: begin
            state_in = S_SQB;
         end
         S_SQB: begin
            u_in     = mul_ff;
            state_in = S_TEST;
         end
         S_TEST: begin
            diff_in = u_ff - mul_ff;
            if (radius_sq > ESCAPE_LIMIT) begin
               if (32'(iter_next) > 32'(COUNT_MAX)) begin
                  count_in = COUNT_W'(COUNT_MAX);
               end else begin
                  count_in = COUNT_W'(iter_next);
               end
               state_in = S_DONE;
            end else begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            a_in = Z_W'(diff_ff >>> FRAC_BITS) + cr_ff;
            b_in = Z_W'(mul_ff >>> (FRAC_BITS - 1)) + ci_ff;
            if (iter_ff == ITER_W'(MAX_ITERATIONS - 1)) begin
               count_in = '0;
               state_in = S_DONE;
            end else begin
               iter_in  = iter_next;
               state_in = S_SQA;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.escape_count = count_ff;
               rsp_payload_in.pixel_color  = blue_palette(count_ff);
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      magx_ff        <= magx_in;
      magy_ff        <= magy_in;
      negx_ff        <= negx_in;
      negy_ff        <= negy_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      cr_ff          <= cr_in;
      ci_ff          <= ci_in;
      mul_ff         <= mul_in;
      u_ff           <= u_in;
      diff_ff        <= diff_in;
      iter_ff        <= iter_in;
      count_ff       <= count_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         c_real_ff <= JULIA_C_REAL_RESET;
         c_imag_ff <= JULIA_C_IMAG_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_FRACTAL_MODE: mode_ff   <= csr_wdata[0];
            CSR_JULIA_C_REAL: c_real_ff <= signed'(csr_wdata);
            CSR_JULIA_C_IMAG: c_imag_ff <= signed'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* test/tb_escape_time_fractal_pixel.sv */
`timescale 1ns / 100ps
// self-checking testbench for escape_time_fractal_pixel, Mandelbrot and Julia modes
// predicts escape count and palette color per pixel, random request idle and response stall
// depends on etfp_pkg and escape_time_fractal_pixel

module tb_escape_time_fractal_pixel;
   import etfp_pkg::*;

   localparam int SCREEN_W     = 320;
   localparam int SCREEN_H     = 240;
   localparam int ITERATIONS   = 16;
   localparam int COORD_DIV    = 80;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 500000;
   localparam longint ESCAPE_Q48 = 64'sd4 <<< (2 * FRAC_BITS);
   localparam logic [127:0] BLUE_RAMP = {8'd255, 8'd223, 8'd191, 8'd159, 8'd127, 8'd95,
                                         8'd63, 8'd31, 8'd30, 8'd29, 8'd28, 8'd27,
                                         8'd26, 8'd25, 8'd24, 8'd0};
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [C_W-1:0]       csr_wdata = '0;

   logic                  julia_mode = 1'b0;
   logic signed [C_W-1:0] julia_re = JULIA_C_REAL_RESET;
   logic signed [C_W-1:0] julia_im = JULIA_C_IMAG_RESET;
   rsp_payload_type       expected_pixels[$];

   int mismatches    = 0;
   int cycle_count   = 0;
   int idle_pct      = 12;
   int stall_pct     = 12;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   escape_time_fractal_pixel #(
      .SCREEN_WIDTH  (SCREEN_W),
      .SCREEN_HEIGHT (SCREEN_H),
      .MAX_ITERATIONS(ITERATIONS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic longint coord_to_q24(input longint delta);
      longint mag;
      longint q;
      mag = (delta < 0) ? -delta : delta;
      q = ((mag <<< FRAC_BITS) + COORD_DIV / 2) / COORD_DIV;
      return (delta < 0) ? -q : q;
   endfunction

   function automatic rsp_payload_type predict_escape(input logic [8:0] px,
                                                     input logic [7:0] py);
      longint a, b, cr, ci, u, t, b_next;
      int n;
      int count;
      int idx;
      rsp_payload_type res;
      a = coord_to_q24(longint'(px) - SCREEN_W / 2);
      b = coord_to_q24(longint'(py) - SCREEN_H / 2);
      if (julia_mode) begin
         cr = julia_re;
         ci = julia_im;
      end else begin
         cr = a;
         ci = b;
      end
      count = 0;
      for (n = 0; n < ITERATIONS && count == 0; n++) begin
         u = a * a;
         t = b * b;
         if (u + t > ESCAPE_Q48) begin
            count = n + 1;
         end else begin
            b_next = ((2 * a * b) >>> FRAC_BITS) + ci;
            a = ((u - t) >>> FRAC_BITS) + cr;
            b = b_next;
         end
      end
      if (count > COUNT_MAX) count = COUNT_MAX;
      idx = (count > 15) ? 15 : count;
      res.escape_count = count[COUNT_W-1:0];
      res.pixel_color = BLUE_RAMP[idx*8 +: 8];
      return res;
   endfunction

   function automatic logic [C_W-1:0] random_julia_c(input bit full_range);
      logic [31:0] r;
      if (full_range) r = $urandom;
      else r = $urandom_range(33554432) - 32'd16777216;
      return r[C_W-1:0];
   endfunction

   task automatic send_pixel(input logic [8:0] px, input logic [7:0] py);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= {px, py};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_pixels.push_back(predict_escape(px, py));
   endtask

   task automatic wait_results_done;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [C_W-1:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_FRACTAL_MODE: julia_mode = value[0];
         CSR_JULIA_C_REAL: julia_re = value;
         CSR_JULIA_C_IMAG: julia_im = value;
         default: ;
      endcase
   endtask

   task automatic write_mode(input logic julia);
      logic [31:0] r;
      r = $urandom;
      write_csr(CSR_FRACTAL_MODE, {r[C_W-1:1], julia});
   endtask

   task automatic send_random_pixels(input int count);
      int k;
      int pick;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 50)
            send_pixel(9'($urandom_range(200)), 8'($urandom_range(200, 40)));
         else if (pick < 85)
            send_pixel(9'($urandom_range(SCREEN_W - 1)), 8'($urandom_range(SCREEN_H - 1)));
         else
            send_pixel(9'($urandom_range(511)), 8'($urandom_range(255)));
      end
   endtask

   task automatic test_field_extremes;
      send_pixel(9'd0, 8'd0);
      send_pixel(9'd511, 8'd255);
      send_pixel(9'd160, 8'd120);
      send_pixel(9'd319, 8'd239);
      wait_results_done;
   endtask

   task automatic test_every_count;
      int found_x [17];
      int found_y [17];
      int found;
      int x, y, k;
      rsp_payload_type r;
      for (k = 0; k < 17; k++) found_x[k] = -1;
      found = 0;
      for (y = 0; y < SCREEN_H && found < 16; y++) begin
         for (x = 0; x < SCREEN_W && found < 16; x++) begin
            r = predict_escape(9'(x), 8'(y));
            k = r.escape_count;
            if (k != 0 && k < 17 && found_x[k] < 0) begin
               found_x[k] = x;
               found_y[k] = y;
               found++;
            end
         end
      end
      for (k = 1; k < 17; k++)
         if (found_x[k] >= 0) send_pixel(9'(found_x[k]), 8'(found_y[k]));
      wait_results_done;
   endtask

   task automatic test_julia_extremes;
      write_mode(1'b1);
      send_pixel(9'd160, 8'd120);
      wait_results_done;
      write_csr(CSR_JULIA_C_REAL, 27'h3FF_FFFF);
      write_csr(CSR_JULIA_C_IMAG, 27'h400_0000);
      send_pixel(9'd160, 8'd120);
      wait_results_done;
      // write to an unmapped index leaves the constants alone
      write_csr(CSR_UNMAPPED, random_julia_c(1'b1));
      send_pixel(9'd100, 8'd100);
      wait_results_done;
      write_csr(CSR_JULIA_C_REAL, 27'd33554432);
      write_csr(CSR_JULIA_C_IMAG, -27'sd33554432);
      send_pixel(9'd160, 8'd120);
      wait_results_done;
   endtask

   task automatic test_random_julia;
      int phase;
      for (phase = 0; phase < 4; phase++) begin
         write_mode(1'b1);
         write_csr(CSR_JULIA_C_REAL, random_julia_c(phase == 3));
         write_csr(CSR_JULIA_C_IMAG, random_julia_c(phase == 3));
         send_random_pixels(50);
         wait_results_done;
      end
   endtask

   task automatic test_random_mandelbrot;
      write_mode(1'b0);
      send_random_pixels(240);
      wait_results_done;
   endtask

   task automatic test_no_idle_stretch;
      idle_pct = 0;
      stall_pct = 0;
      send_random_pixels(150);
      wait_results_done;
      idle_pct = 12;
      stall_pct = 12;
   endtask

   task automatic test_output_backpressure;
      hold_requests++;
      idle_pct = 0;
      send_random_pixels(12);
      wait_results_done;
      idle_pct = 12;
   endtask

   task automatic test_pause_between_bursts;
      int burst;
      for (burst = 0; burst < 5; burst++) begin
         send_random_pixels(20);
         wait_results_done;
      end
   endtask

   // receiver side: random stall, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_left == 0 && hold_requests != holds_served) begin
         hold_left = HOLD_CYCLES;
         holds_served++;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected transaction: escape_count %0d pixel_color %0d",
                   rsp_payload.escape_count, rsp_payload.pixel_color);
            mismatches++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_payload.escape_count !== want.escape_count) begin
               $error("escape_count expected %0d actual %0d",
                      want.escape_count, rsp_payload.escape_count);
               mismatches++;
            end
            if (rsp_payload.pixel_color !== want.pixel_color) begin
               $error("pixel_color expected %0d actual %0d",
                      want.pixel_color, rsp_payload.pixel_color);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes;
      test_every_count;
      test_julia_extremes;
      test_random_mandelbrot;
      test_no_idle_stretch;
      test_output_backpressure;
      test_random_julia;
      write_mode(1'b0);
      test_pause_between_bursts;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
